FILE: rtl/core/rfa_pkg.sv
// Shared types, codes and constants of the repulsive field accumulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package rfa_pkg;

    // Default number of fraction bits of the fixed-point formats.
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAFETY_DIST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REP_GAIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_GAIN    = 2'd3;

    // One map leaf.
    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               occupied;
        logic               last_leaf;
    } t_in_item;

    // One result.
    typedef struct packed {
        logic signed [47:0] accel_x;
        logic signed [47:0] accel_y;
        logic signed [47:0] accel_z;
        logic               saturated;
    } t_out_item;

    // Datapath operation codes.
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE  = 4'd0;
    localparam t_op OP_SQ    = 4'd1;
    localparam t_op OP_SQRT  = 4'd2;
    localparam t_op OP_INVD  = 4'd3;
    localparam t_op OP_INVD0 = 4'd4;
    localparam t_op OP_MAGG  = 4'd5;
    localparam t_op OP_MAGD  = 4'd6;
    localparam t_op OP_U     = 4'd7;
    localparam t_op OP_TERM  = 4'd8;
    localparam t_op OP_EMIT  = 4'd9;

    // Axis codes.
    typedef logic [1:0] t_axis;
    localparam t_axis AX_X = 2'd0;
    localparam t_axis AX_Y = 2'd1;
    localparam t_axis AX_Z = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load;
        logic  clear;
        logic  start;
        t_op   op;
        t_axis axis;
        logic  push;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic enable;
        logic occupied;
        logic last;
        logic in_range;
        logic out_busy;
    } t_status;

endpackage

FILE: rtl/core/repulsive_field_accumulator.sv
// Repulsive field accumulator: one map leaf per transfer, one leaf at a time. Most of the
// time of an occupied leaf in range goes to the 32-step square root and the five divisions,
// each taking one quotient bit per cycle, plus nine passes through the four-step shared
// multiplier. The last leaf also scales the sums; a finished result waits in the output
// register while the next leaves are taken, and the block waits only if a second result is
// ready before it.
// Depends on rfa_pkg, rfa_ctrl, rfa_dp.
module repulsive_field_accumulator
    import rfa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    rfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rfa_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

FILE: rtl/core/rfa_mul.sv
// Sequential 64 x 64 multiplier built from one 32 x 32 multiplier.
// Four partial products, one after another; depends on nothing.
module rfa_mul (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_a,
    input  logic [63:0]   i_b,
    output logic          o_done,
    output logic [127:0]  o_prod
);

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic [2:0]   r_phase;
    logic         r_busy;
    logic [63:0]  r_pp;
    logic [1:0]   r_sh;
    logic         r_pp_vld;
    logic [127:0] r_acc;
    logic         r_done;

    logic [31:0]  w_a_part;
    logic [31:0]  w_b_part;
    logic [127:0] w_pp_shifted;

    // Select the halves for the current partial product.
    assign w_a_part = r_phase[1] ? r_a[63:32] : r_a[31:0];
    assign w_b_part = r_phase[0] ? r_b[63:32] : r_b[31:0];

    // Align the registered partial product.
    always_comb begin
        unique case (r_sh)
            2'd0:    w_pp_shifted = {64'd0, r_pp};
            2'd1:    w_pp_shifted = {32'd0, r_pp, 32'd0};
            2'd2:    w_pp_shifted = {r_pp, 64'd0};
            default: w_pp_shifted = '0;
        endcase
    end

    // Control of the phase sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_phase  <= '0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_phase  <= '0;
                r_pp_vld <= 1'b0;
            end else if (r_busy) begin
                r_pp_vld <= ~r_phase[2];
                r_phase  <= r_phase + 3'd1;
                if (r_phase[2]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else begin
                r_pp_vld <= 1'b0;
            end
        end
    end

    // Partial products and accumulation.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else begin
            if (r_busy && !r_phase[2]) begin
                r_pp <= w_a_part * w_b_part;
                r_sh <= 2'({1'b0, r_phase[1]} + {1'b0, r_phase[0]});
            end
            if (r_pp_vld) begin
                r_acc <= r_acc + w_pp_shifted;
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: rtl/core/rfa_div.sv
// Restoring divider, one quotient bit per cycle, by a 32-bit divisor.
// Depends on nothing.
module rfa_div #(
    parameter int W = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_dividend,
    input  logic [31:0]   i_divisor,
    output logic          o_done,
    output logic [W-1:0]  o_quot
);

    localparam int CNT_W = $clog2(W + 1);

    logic [32:0]      r_rem;
    logic [W-1:0]     r_quot;
    logic [31:0]      r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [32:0] w_shift;
    logic        w_ge;

    // Bring down the next dividend bit and trial-subtract.
    assign w_shift = {r_rem[31:0], r_quot[W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? (w_shift - {1'b0, r_dvs}) : w_shift;
            r_quot <= {r_quot[W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/core/rfa_dp.sv
// Datapath: configuration, leaf capture, square root, shared multiplier and
// divider, running sums and the output register. Depends on rfa_pkg, rfa_mul, rfa_div.
module rfa_dp
    import rfa_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_in_item             i_in_data,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int DIV_W = 32 + FRAC_BITS;
    localparam logic [31:0] EPS_RAW  = 32'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [31:0] D0_RST   = 32'(30 << FRAC_BITS);
    localparam logic [31:0] GAIN_RST = 32'(1 << FRAC_BITS);
    localparam logic [63:0] SAT_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SAT_NEG  = 64'h8000_0000_0000_0000;
    localparam logic [63:0] OUT_MAX  = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] OUT_MINM = 64'h0000_8000_0000_0000;

    // Configuration.
    logic        r_en;
    logic [31:0] r_d0;
    logic [31:0] r_gain;
    logic [31:0] r_ogain;

    // Captured leaf.
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_pz;
    logic               r_occ;
    logic               r_last;

    // Per-point intermediate values.
    logic [63:0]      r_dsq;
    logic [31:0]      r_d;
    logic [DIV_W-1:0] r_inv_d;
    logic [DIV_W-1:0] r_inv_d0;
    logic [DIV_W-1:0] r_u;
    logic [63:0]      r_mag;
    logic [63:0]      r_term;
    logic             r_acc_go;

    // Running state.
    logic signed [63:0] r_sum_x;
    logic signed [63:0] r_sum_y;
    logic signed [63:0] r_sum_z;
    logic               r_clip;

    // Operation in flight.
    t_op   r_op;
    t_axis r_axis;
    logic  r_done;

    // Square root.
    logic [63:0] r_sq_v;
    logic [63:0] r_sq_res;
    logic [63:0] r_sq_bit;
    logic        r_sq_busy;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    logic signed [31:0] w_p_cmd;
    logic signed [31:0] w_p_op;
    logic [31:0]        w_pabs_cmd;
    logic signed [63:0] w_sum_cmd;
    logic signed [63:0] w_sum_op;
    logic [63:0]        w_sabs_cmd;
    logic [DIV_W-1:0]   w_diff;

    logic          w_mul_start;
    logic [63:0]   w_mul_a;
    logic [63:0]   w_mul_b;
    logic          w_mul_done;
    logic [127:0]  w_prod;

    logic             w_div_start;
    logic [DIV_W-1:0] w_div_dvd;
    logic [31:0]      w_div_dvs;
    logic             w_div_done;
    logic [DIV_W-1:0] w_quot;

    logic [63:0] w_mshift;
    logic        w_movf;
    logic        w_cap_hit;
    logic [63:0] w_capped;

    logic        w_emit_hit;
    logic [47:0] w_emit_val;

    logic signed [63:0] w_delta;
    logic        [64:0] w_acc65;
    logic               w_acc_ovf;
    logic signed [63:0] w_acc_val;

    logic [63:0] w_sq_trial;
    logic        w_sq_ge;
    logic [63:0] w_sq_next;
    logic        w_in_range;

    // Point coordinate and sum selected by the command axis and the latched axis.
    always_comb begin
        unique case (i_cmd.axis)
            AX_X:    begin w_p_cmd = r_px; w_sum_cmd = r_sum_x; end
            AX_Y:    begin w_p_cmd = r_py; w_sum_cmd = r_sum_y; end
            AX_Z:    begin w_p_cmd = r_pz; w_sum_cmd = r_sum_z; end
            default: begin w_p_cmd = '0;   w_sum_cmd = '0;      end
        endcase
        unique case (r_axis)
            AX_X:    begin w_p_op = r_px; w_sum_op = r_sum_x; end
            AX_Y:    begin w_p_op = r_py; w_sum_op = r_sum_y; end
            AX_Z:    begin w_p_op = r_pz; w_sum_op = r_sum_z; end
            default: begin w_p_op = '0;   w_sum_op = '0;      end
        endcase
    end

    assign w_pabs_cmd = w_p_cmd[31] ? (32'd0 - 32'(w_p_cmd)) : 32'(w_p_cmd);
    assign w_sabs_cmd = w_sum_cmd[63] ? (64'd0 - 64'(w_sum_cmd)) : 64'(w_sum_cmd);
    assign w_diff     = r_inv_d - r_inv_d0;

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        unique case (i_cmd.op)
            OP_SQ: begin
                w_mul_start = i_cmd.start;
                w_mul_a     = {32'd0, w_pabs_cmd};
                w_mul_b     = {32'd0, w_pabs_cmd};
            end
            OP_MAGG: begin
                w_mul_start = i_cmd.start;
                w_mul_a     = {32'd0, r_gain};
                w_mul_b     = 64'(w_diff);
            end
            OP_MAGD: begin
                w_mul_start = i_cmd.start;
                w_mul_a     = r_mag;
                w_mul_b     = 64'(r_inv_d);
            end
            OP_TERM: begin
                w_mul_start = i_cmd.start;
                w_mul_a     = r_mag;
                w_mul_b     = 64'(r_u);
            end
            OP_EMIT: begin
                w_mul_start = i_cmd.start;
                w_mul_a     = w_sabs_cmd;
                w_mul_b     = {32'd0, r_ogain};
            end
            default: begin
                w_mul_start = 1'b0;
            end
        endcase
    end

    // Operand selection for the shared divider.
    always_comb begin
        w_div_start = 1'b0;
        w_div_dvd   = DIV_W'(1) << (2 * FRAC_BITS);
        w_div_dvs   = r_d;
        unique case (i_cmd.op)
            OP_INVD: begin
                w_div_start = i_cmd.start;
            end
            OP_INVD0: begin
                w_div_start = i_cmd.start;
                w_div_dvs   = r_d0;
            end
            OP_U: begin
                w_div_start = i_cmd.start;
                w_div_dvd   = DIV_W'(w_pabs_cmd) << FRAC_BITS;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    rfa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    rfa_div #(.W(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Product scaled back by the fraction bits, with the 63-bit cap.
    assign w_mshift  = w_prod[63+FRAC_BITS:FRAC_BITS];
    assign w_movf    = |w_prod[127:64+FRAC_BITS];
    assign w_cap_hit = w_movf | w_mshift[63];
    assign w_capped  = w_cap_hit ? SAT_POS : w_mshift;

    // Output scaling with saturation to 48 bits.
    always_comb begin
        if (w_sum_op[63]) begin
            w_emit_hit = w_movf || (w_mshift > OUT_MINM);
            w_emit_val = w_emit_hit ? 48'(64'd0 - OUT_MINM) : 48'(64'd0 - w_mshift);
        end else begin
            w_emit_hit = w_movf || (w_mshift > OUT_MAX);
            w_emit_val = w_emit_hit ? OUT_MAX[47:0] : w_mshift[47:0];
        end
    end

    // Saturating accumulation of the term against the point's sign.
    assign w_delta   = w_p_op[31] ? $signed(r_term) : -$signed(r_term);
    assign w_acc65   = {w_sum_op[63], w_sum_op} + {w_delta[63], w_delta};
    assign w_acc_ovf = (w_acc65[64] != w_acc65[63]);
    assign w_acc_val = w_acc_ovf ? (w_acc65[64] ? $signed(SAT_NEG) : $signed(SAT_POS))
                                 : $signed(w_acc65[63:0]);

    // One step of the bit-by-bit square root.
    assign w_sq_trial = r_sq_res + r_sq_bit;
    assign w_sq_ge    = (r_sq_v >= w_sq_trial);
    assign w_sq_next  = w_sq_ge ? ((r_sq_res >> 1) + r_sq_bit) : (r_sq_res >> 1);

    assign w_in_range = (r_d > EPS_RAW) && (r_d < r_d0) && (r_d != 32'd0);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b1;
            r_d0    <= D0_RST;
            r_gain  <= GAIN_RST;
            r_ogain <= GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE:      r_en    <= i_cfg_data[0];
                REG_SAFETY_DIST: r_d0    <= i_cfg_data;
                REG_REP_GAIN:    r_gain  <= i_cfg_data;
                REG_OUT_GAIN:    r_ogain <= i_cfg_data;
                default:         r_en    <= r_en;
            endcase
        end
    end

    // Leaf capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px   <= i_in_data.point_x;
            r_py   <= i_in_data.point_y;
            r_pz   <= i_in_data.point_z;
            r_occ  <= i_in_data.occupied;
            r_last <= i_in_data.last_leaf;
        end
    end

    // Operation tracking and square-root control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op      <= OP_NONE;
            r_axis    <= AX_X;
            r_sq_busy <= 1'b0;
            r_acc_go  <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_acc_go <= 1'b0;
            if (i_cmd.start) begin
                r_op   <= i_cmd.op;
                r_axis <= i_cmd.axis;
            end
            if (i_cmd.start && (i_cmd.op == OP_SQRT)) begin
                r_sq_busy <= 1'b1;
            end else if (r_sq_busy && r_sq_bit[0]) begin
                r_sq_busy <= 1'b0;
                r_done    <= 1'b1;
            end
            if (w_mul_done) begin
                if (r_op == OP_TERM) begin
                    r_acc_go <= 1'b1;
                end else begin
                    r_done <= 1'b1;
                end
            end
            if (w_div_done || r_acc_go) begin
                r_done <= 1'b1;
            end
        end
    end

    // Square-root iteration registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && (i_cmd.op == OP_SQRT)) begin
            r_sq_v   <= r_dsq;
            r_sq_res <= '0;
            r_sq_bit <= 64'd1 << 62;
        end else if (r_sq_busy) begin
            if (w_sq_ge) begin
                r_sq_v <= r_sq_v - w_sq_trial;
            end
            r_sq_res <= w_sq_next;
            r_sq_bit <= r_sq_bit >> 2;
            if (r_sq_bit[0]) begin
                r_d <= w_sq_next[31:0];
            end
        end
    end

    // Write-back of multiplier and divider results.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dsq <= '0;
        end else if (w_mul_done && (r_op == OP_SQ)) begin
            r_dsq <= r_dsq + w_prod[63:0];
        end
        if (w_mul_done && ((r_op == OP_MAGG) || (r_op == OP_MAGD))) begin
            r_mag <= w_capped;
        end
        if (w_mul_done && (r_op == OP_TERM)) begin
            r_term <= w_capped;
        end
        if (w_div_done) begin
            unique case (r_op)
                OP_INVD:  r_inv_d  <= w_quot;
                OP_INVD0: r_inv_d0 <= w_quot;
                OP_U:     r_u      <= w_quot;
                default:  r_u      <= r_u;
            endcase
        end
    end

    // Running sums and the clip flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_clip  <= 1'b0;
        end else if (i_cmd.clear || i_cmd.push) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_clip  <= 1'b0;
        end else begin
            if (w_mul_done && w_cap_hit &&
                ((r_op == OP_MAGG) || (r_op == OP_MAGD) || (r_op == OP_TERM))) begin
                r_clip <= 1'b1;
            end
            if (w_mul_done && (r_op == OP_EMIT) && w_emit_hit) begin
                r_clip <= 1'b1;
            end
            if (r_acc_go) begin
                if (w_acc_ovf) begin
                    r_clip <= 1'b1;
                end
                unique case (r_axis)
                    AX_X:    r_sum_x <= w_acc_val;
                    AX_Y:    r_sum_y <= w_acc_val;
                    AX_Z:    r_sum_z <= w_acc_val;
                    default: r_sum_x <= r_sum_x;
                endcase
            end
        end
    end

    // Output register: filled while empty, emptied by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_done && (r_op == OP_EMIT)) begin
            unique case (r_axis)
                AX_X:    r_out.accel_x <= $signed(w_emit_val);
                AX_Y:    r_out.accel_y <= $signed(w_emit_val);
                AX_Z:    r_out.accel_z <= $signed(w_emit_val);
                default: r_out.accel_x <= r_out.accel_x;
            endcase
        end
        if (i_cmd.push) begin
            r_out.saturated <= r_clip;
        end
    end

    always_comb begin
        o_status.done     = r_done;
        o_status.enable   = r_en;
        o_status.occupied = r_occ;
        o_status.last     = r_last;
        o_status.in_range = w_in_range;
        o_status.out_busy = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTH
    // A result push leaves the sums and the clip flag cleared.
    a_push_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.push) |-> (r_sum_x == 0) && (r_sum_y == 0) && (r_sum_z == 0) && !r_clip)
        else $error("sums not cleared after result push");

    // The unit direction component never exceeds one.
    a_u_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_op == OP_U)) |-> (r_u <= (DIV_W'(1) << FRAC_BITS)))
        else $error("direction component above one");

    // Divisions by d are only started with a nonzero distance.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_start && (i_cmd.op != OP_INVD0)) |-> (r_d != 32'd0))
        else $error("division by zero distance");

    // A push is only issued while the output register is empty.
    a_push_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> !r_out_valid)
        else $error("result pushed over a pending result");
`endif

endmodule

FILE: rtl/core/rfa_ctrl.sv
// Controller state machine: sequences the datapath operations for each leaf.
// Depends on rfa_pkg.
module rfa_ctrl
    import rfa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_SQX   = 5'd2;
    localparam logic [4:0] S_SQY   = 5'd3;
    localparam logic [4:0] S_SQZ   = 5'd4;
    localparam logic [4:0] S_SQRT  = 5'd5;
    localparam logic [4:0] S_INVD  = 5'd6;
    localparam logic [4:0] S_INVD0 = 5'd7;
    localparam logic [4:0] S_MAGG  = 5'd8;
    localparam logic [4:0] S_MAGD1 = 5'd9;
    localparam logic [4:0] S_MAGD2 = 5'd10;
    localparam logic [4:0] S_UX    = 5'd11;
    localparam logic [4:0] S_TX    = 5'd12;
    localparam logic [4:0] S_UY    = 5'd13;
    localparam logic [4:0] S_TY    = 5'd14;
    localparam logic [4:0] S_UZ    = 5'd15;
    localparam logic [4:0] S_TZ    = 5'd16;
    localparam logic [4:0] S_LAST  = 5'd17;
    localparam logic [4:0] S_OWAIT = 5'd18;
    localparam logic [4:0] S_EX    = 5'd19;
    localparam logic [4:0] S_EY    = 5'd20;
    localparam logic [4:0] S_EZ    = 5'd21;
    localparam logic [4:0] S_PUSH  = 5'd22;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_wait;
    logic       n_wait;

    logic       w_is_op;
    t_op        w_op;
    t_axis      w_axis;
    logic [4:0] w_after;

    // Operation, axis and successor of each operation state.
    always_comb begin
        w_is_op = 1'b1;
        w_op    = OP_NONE;
        w_axis  = AX_X;
        w_after = S_IDLE;
        unique case (r_state)
            S_SQX:   begin w_op = OP_SQ;    w_axis = AX_X; w_after = S_SQY;   end
            S_SQY:   begin w_op = OP_SQ;    w_axis = AX_Y; w_after = S_SQZ;   end
            S_SQZ:   begin w_op = OP_SQ;    w_axis = AX_Z; w_after = S_SQRT;  end
            S_SQRT:  begin
                w_op    = OP_SQRT;
                w_after = i_status.in_range ? S_INVD : S_LAST;
            end
            S_INVD:  begin w_op = OP_INVD;  w_after = S_INVD0; end
            S_INVD0: begin w_op = OP_INVD0; w_after = S_MAGG;  end
            S_MAGG:  begin w_op = OP_MAGG;  w_after = S_MAGD1; end
            S_MAGD1: begin w_op = OP_MAGD;  w_after = S_MAGD2; end
            S_MAGD2: begin w_op = OP_MAGD;  w_after = S_UX;    end
            S_UX:    begin w_op = OP_U;     w_axis = AX_X; w_after = S_TX;    end
            S_TX:    begin w_op = OP_TERM;  w_axis = AX_X; w_after = S_UY;    end
            S_UY:    begin w_op = OP_U;     w_axis = AX_Y; w_after = S_TY;    end
            S_TY:    begin w_op = OP_TERM;  w_axis = AX_Y; w_after = S_UZ;    end
            S_UZ:    begin w_op = OP_U;     w_axis = AX_Z; w_after = S_TZ;    end
            S_TZ:    begin w_op = OP_TERM;  w_axis = AX_Z; w_after = S_LAST;  end
            S_EX:    begin w_op = OP_EMIT;  w_axis = AX_X; w_after = S_EY;    end
            S_EY:    begin w_op = OP_EMIT;  w_axis = AX_Y; w_after = S_EZ;    end
            S_EZ:    begin w_op = OP_EMIT;  w_axis = AX_Z; w_after = S_PUSH;  end
            default: begin w_is_op = 1'b0; end
        endcase
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_wait      = r_wait;
        o_cmd.load  = 1'b0;
        o_cmd.clear = 1'b0;
        o_cmd.start = 1'b0;
        o_cmd.op    = w_op;
        o_cmd.axis  = w_axis;
        o_cmd.push  = 1'b0;
        if (w_is_op) begin
            if (!r_wait) begin
                o_cmd.start = 1'b1;
                n_wait      = 1'b1;
            end else if (i_status.done) begin
                n_wait  = 1'b0;
                n_state = w_after;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_DISP;
                    end
                end
                S_DISP: begin
                    if (!i_status.enable) begin
                        o_cmd.clear = i_status.last;
                        n_state     = S_IDLE;
                    end else if (i_status.occupied) begin
                        n_state = S_SQX;
                    end else begin
                        n_state = S_LAST;
                    end
                end
                S_LAST: begin
                    n_state = i_status.last ? S_OWAIT : S_IDLE;
                end
                S_OWAIT: begin
                    if (!i_status.out_busy) begin
                        n_state = S_EX;
                    end
                end
                S_PUSH: begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
                default: begin
                    n_state = S_IDLE;
                    n_wait  = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
